FILE: hdl/tlc_pkg.sv
// Shared types and codes for the two-level cache hit/miss model.
// Used by tlc_level, two_level_cache_hit_miss_model and its checker.
package tlc_pkg;

   // access state reported for each cache level
   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_READ_HIT   = 3'd1,
      ST_READ_MISS  = 3'd2,
      ST_WRITE_HIT  = 3'd3,
      ST_WRITE_MISS = 3'd4
   } tlc_status_type;

   // sequencer states
   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LOOK
   } tlc_fsm_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_L1_OFFSET = 3'd0,
      REG_L1_INDEX  = 3'd1,
      REG_L1_WAYS   = 3'd2,
      REG_L2_OFFSET = 3'd3,
      REG_L2_INDEX  = 3'd4,
      REG_L2_WAYS   = 3'd5
   } tlc_reg_type;

   localparam logic OP_WRITE = 1'b1;

   // control from the sequencer to one cache level
   typedef struct packed {
      logic rd_en;     // read the set row of the incoming address
      logic look;      // row data valid, update and write back
      logic enable;    // level takes part in this access
      logic is_write;  // access kind
      logic clear;     // clear the row at the sweep index
   } tlc_lvl_ctl_type;

endpackage

FILE: hdl/tlc_level.sv
// One cache level: set-row tag memory, hit lookup, fill and round-robin victim.
// Depends on tlc_pkg.
module tlc_level
   import tlc_pkg::*;
#(
   parameter int SETS = 256,
   parameter int WAYS = 4,
   parameter int CWW  = 3,
   parameter int IW   = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [3:0]      cfg_off,
   input  logic [3:0]      cfg_ib,
   input  logic [CWW-1:0]  cfg_ways,
   input  logic [31:0]     req_addr,
   input  logic [IW-1:0]   clr_idx,
   input  tlc_lvl_ctl_type ctl,
   output logic            hit
);

   localparam int VW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RW = WAYS * 34;

   logic [RW-1:0] mem [SETS];
   logic [RW-1:0] row_ff;
   logic [31:0]   addr_ff;
   logic [IW-1:0] idx_ff;
   logic [VW-1:0] ctr_ff, ctr_in;

   logic [16:0]   sel;
   logic [IW-1:0] idx_in;
   logic [4:0]    eff;
   logic [31:0]   tmask;
   logic [WAYS-1:0] hitv;
   logic [VW-1:0] hit_way, inv_way, victim;
   logic          inv_found;
   logic [4:0]    vic_ctr, vic_nxt;
   logic [RW-1:0] row_new;
   logic          do_fill, do_dirty;

   // set index of the incoming address
   always_comb begin
      sel    = 17'(req_addr >> cfg_off) & ((17'd1 << cfg_ib) - 17'd1);
      idx_in = IW'(sel % 17'(SETS));
   end

   // clamp ways in use, build tag compare mask
   always_comb begin
      if (cfg_ways == '0) begin
         eff = 5'd1;
      end else if (5'(cfg_ways) > 5'(WAYS)) begin
         eff = 5'(WAYS);
      end else begin
         eff = 5'(cfg_ways);
      end
      tmask = 32'hFFFF_FFFF << (5'(cfg_off) + 5'(cfg_ib));
   end

   // compare every valid way, pick lowest hit and lowest invalid way
   always_comb begin
      hitv      = '0;
      hit_way   = '0;
      inv_way   = '0;
      inv_found = 1'b0;
      hit       = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (5'(w) < eff) begin
            hitv[w] = row_ff[WAYS*32 + w] &&
                      (((row_ff[w*32 +: 32] ^ addr_ff) & tmask) == 32'd0);
            if (hitv[w]) begin
               hit_way = VW'(w);
               hit     = 1'b1;
            end
            if (!row_ff[WAYS*32 + w]) begin
               inv_way   = VW'(w);
               inv_found = 1'b1;
            end
         end
      end
   end

   // choose the victim and advance the round-robin counter
   always_comb begin
      vic_ctr = (5'(ctr_ff) < eff) ? 5'(ctr_ff) : 5'd0;
      vic_nxt = ((vic_ctr + 5'd1) >= eff) ? 5'd0 : vic_ctr + 5'd1;
      do_fill  = ctl.look && ctl.enable && !hit && !ctl.is_write;
      do_dirty = ctl.look && ctl.enable && hit && ctl.is_write;
      victim   = inv_found ? inv_way : VW'(vic_ctr);
      ctr_in   = ctr_ff;
      if (do_fill && !inv_found) begin
         ctr_in = VW'(vic_nxt);
      end
      row_new = row_ff;
      if (do_fill) begin
         row_new[32*victim +: 32]      = addr_ff;
         row_new[WAYS*32 + victim]     = 1'b1;
         row_new[WAYS*33 + victim]     = 1'b0;
      end
      if (do_dirty) begin
         row_new[WAYS*33 + hit_way]    = 1'b1;
      end
   end

   // victim counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   // memory port: sweep clear, write back, registered read
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[clr_idx] <= '0;
      end else if (do_fill || do_dirty) begin
         mem[idx_ff] <= row_new;
      end
      if (ctl.rd_en) begin
         row_ff  <= mem[idx_in];
         addr_ff <= req_addr;
         idx_ff  <= idx_in;
      end
   end

endmodule

FILE: hdl/two_level_cache_hit_miss_model.sv
// Two-level cache hit/miss model: a request reads its tag rows, then updates and
// writes them back while the result loads; no new request is taken until then.
// Both levels read their set rows in parallel from single-port memories.
// Reset is synchronous; afterwards a clearing pass over max(L1_SETS, L2_SETS)
// set indexes empties both tag stores, during which no request is taken.
// Depends on tlc_pkg and tlc_level.
module two_level_cache_hit_miss_model
   import tlc_pkg::*;
#(
   parameter int L1_SETS = 256,
   parameter int L1_WAYS = 4,
   parameter int L2_SETS = 1024,
   parameter int L2_WAYS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_l1_status,
   output logic [2:0]  rsp_l2_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int I1W  = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
   localparam int I2W  = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
   localparam int MAXS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
   localparam int CW   = $clog2(MAXS + 1);

   tlc_fsm_type     state_ff, state_in;
   logic [CW-1:0]   clr_ff, clr_in;
   logic            op_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   tlc_status_type  l1_st_ff, l2_st_ff, l1_st, l2_st;
   logic [3:0]      l1_off_ff, l1_ib_ff, l2_off_ff, l2_ib_ff, l2_ways_ff;
   logic [2:0]      l1_ways_ff;
   tlc_lvl_ctl_type ctl1, ctl2;
   logic            hit1, hit2, accept, csr_wr, clr_last;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_off_ff  <= 4'd6;
         l1_ib_ff   <= 4'd8;
         l1_ways_ff <= 3'd4;
         l2_off_ff  <= 4'd6;
         l2_ib_ff   <= 4'd10;
         l2_ways_ff <= 4'd8;
      end else if (csr_wr) begin
         case (tlc_reg_type'(csr_paddr[4:2]))
            REG_L1_OFFSET: l1_off_ff  <= csr_pwdata[3:0];
            REG_L1_INDEX:  l1_ib_ff   <= csr_pwdata[3:0];
            REG_L1_WAYS:   l1_ways_ff <= csr_pwdata[2:0];
            REG_L2_OFFSET: l2_off_ff  <= csr_pwdata[3:0];
            REG_L2_INDEX:  l2_ib_ff   <= csr_pwdata[3:0];
            REG_L2_WAYS:   l2_ways_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (tlc_reg_type'(csr_paddr[4:2]))
         REG_L1_OFFSET: csr_prdata = 32'(l1_off_ff);
         REG_L1_INDEX:  csr_prdata = 32'(l1_ib_ff);
         REG_L1_WAYS:   csr_prdata = 32'(l1_ways_ff);
         REG_L2_OFFSET: csr_prdata = 32'(l2_off_ff);
         REG_L2_INDEX:  csr_prdata = 32'(l2_ib_ff);
         REG_L2_WAYS:   csr_prdata = 32'(l2_ways_ff);
         default:       csr_prdata = 32'd0;
      endcase
   end

   // take a request only when idle and the result slot is free by then
   assign req_stall = !((state_ff == FSM_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign clr_last  = (clr_ff == CW'(MAXS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: if (clr_last) state_in = FSM_IDLE;
         FSM_IDLE:  if (accept) state_in = FSM_LOOK;
         FSM_LOOK:  state_in = FSM_IDLE;
         default:   state_in = FSM_CLEAR;
      endcase
   end

   // level controls and clear sweep count
   always_comb begin
      clr_in = clr_ff;
      ctl1   = '0;
      ctl2   = '0;
      case (state_ff)
         FSM_CLEAR: begin
            clr_in     = clr_ff + CW'(1);
            ctl1.clear = (clr_ff < CW'(L1_SETS));
            ctl2.clear = (clr_ff < CW'(L2_SETS));
         end
         FSM_IDLE: begin
            ctl1.rd_en = accept;
            ctl2.rd_en = accept;
         end
         FSM_LOOK: begin
            ctl1.look = 1'b1;
            ctl2.look = 1'b1;
         end
         default: ;
      endcase
      ctl1.enable   = 1'b1;
      ctl1.is_write = op_ff;
      ctl2.enable   = !hit1;
      ctl2.is_write = op_ff;
   end

   // per-level access state
   always_comb begin
      if (hit1) begin
         l1_st = (op_ff == OP_WRITE) ? ST_WRITE_HIT : ST_READ_HIT;
         l2_st = ST_NONE;
      end else begin
         l1_st = (op_ff == OP_WRITE) ? ST_WRITE_MISS : ST_READ_MISS;
         if (hit2) begin
            l2_st = (op_ff == OP_WRITE) ? ST_WRITE_HIT : ST_READ_HIT;
         end else begin
            l2_st = (op_ff == OP_WRITE) ? ST_WRITE_MISS : ST_READ_MISS;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == FSM_LOOK) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold request kind, load result
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
      end
      if (state_ff == FSM_LOOK) begin
         l1_st_ff <= l1_st;
         l2_st_ff <= l2_st;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_l1_status = l1_st_ff;
   assign rsp_l2_status = l2_st_ff;

   tlc_level #(.SETS(L1_SETS), .WAYS(L1_WAYS), .CWW(3)) u_l1 (
      .clock    (clock),
      .reset    (reset),
      .cfg_off  (l1_off_ff),
      .cfg_ib   (l1_ib_ff),
      .cfg_ways (l1_ways_ff),
      .req_addr (req_address),
      .clr_idx  (clr_ff[I1W-1:0]),
      .ctl      (ctl1),
      .hit      (hit1)
   );

   tlc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS), .CWW(4)) u_l2 (
      .clock    (clock),
      .reset    (reset),
      .cfg_off  (l2_off_ff),
      .cfg_ib   (l2_ib_ff),
      .cfg_ways (l2_ways_ff),
      .req_addr (req_address),
      .clr_idx  (clr_ff[I2W-1:0]),
      .ctl      (ctl2),
      .hit      (hit2)
   );

endmodule

FILE: hdl/tlc_checker.sv
// Port-level checks for two_level_cache_hit_miss_model, bound to the top.
// Depends on tlc_pkg.
module tlc_checker
   import tlc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_l1_status,
   input logic [2:0] rsp_l2_status
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // every transfer in yields a result once the LOOK state has loaded it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("missing result after transfer");

   // an L1 hit never reports L2 activity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_l1_status == ST_READ_HIT || rsp_l1_status == ST_WRITE_HIT)
      |-> rsp_l2_status == ST_NONE)
      else $error("L2 state on L1 hit");

   // an L1 read miss always reports an L2 read state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_l1_status == ST_READ_MISS
      |-> (rsp_l2_status == ST_READ_HIT || rsp_l2_status == ST_READ_MISS))
      else $error("bad L2 state on L1 read miss");

endmodule

bind two_level_cache_hit_miss_model tlc_checker u_tlc_checker (.*);
